/* rtl/epas_pkg.sv */
`timescale 1ns / 1ps

package epas_pkg;

    localparam int MAX_REQUEST_BYTES = 1008;

    localparam int ADDR_W   = 16;
    localparam int COUNT_W  = 10;
    localparam int PSIZE_W  = 9;
    localparam int PAGES_W  = 13;
    localparam int CAP_W    = 21;
    localparam int CFG_W    = 13;
    localparam int DIV_STEPS = ADDR_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic [PSIZE_W-1:0] PSIZE_MIN = PSIZE_W'(16);
    localparam logic [PSIZE_W-1:0] PSIZE_MAX = PSIZE_W'(256);

    localparam logic [7:0]         RST_DEVICE_ADDRESS = 8'hA0;
    localparam logic [1:0]         RST_ADDRESSING_MODE = 2'd2;
    localparam logic [PSIZE_W-1:0] RST_PAGE_SIZE = PSIZE_W'(16);
    localparam logic [PAGES_W-1:0] RST_PAGES_PER_DEVICE = PAGES_W'(128);

    typedef enum logic [1:0] {
        CFG_DEVICE_ADDRESS   = 2'd0,
        CFG_ADDRESSING_MODE  = 2'd1,
        CFG_PAGE_SIZE        = 2'd2,
        CFG_PAGES_PER_DEVICE = 2'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        MODE_ONE_BYTE     = 2'd0,
        MODE_TWO_BYTE     = 2'd1,
        MODE_EIGHT_PLUS_X = 2'd2,
        MODE_INVALID      = 2'd3
    } addr_mode_t;

    typedef enum logic [2:0] {
        ST_CHUNK = 3'd0,
        ST_EMPTY = 3'd1,
        ST_RANGE = 3'd2,
        ST_MODE  = 3'd3,
        ST_LONG  = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CAP,
        S_CHECK,
        S_DIV,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic calc_cap;
        logic check;
        logic div_step;
        logic advance;
    } epas_cmd_t;

    typedef struct packed {
        status_t check_code;
        logic    final_result;
    } epas_sts_t;

endpackage

/* rtl/epas_controller.sv */
`timescale 1ns / 1ps

module epas_controller
    import epas_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    output logic      m_tvalid,
    input  logic      m_tready,
    input  epas_sts_t sts,
    output epas_cmd_t cmd
);

    state_t               state_reg, state_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_CAP;
                end
            end
            S_CAP: begin
                cmd.calc_cap = 1'b1;
                state_next   = S_CHECK;
            end
            S_CHECK: begin
                cmd.check = 1'b1;
                cnt_next  = '0;
                if (sts.check_code != ST_CHUNK) begin
                    state_next = S_EMIT;
                end else begin
                    state_next = S_DIV;
                end
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT: begin
                m_tvalid = 1'b1;
                if (m_tready) begin
                    cmd.advance = 1'b1;
                    if (sts.final_result) begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

/* rtl/epas_datapath.sv */
`timescale 1ns / 1ps

module epas_datapath
    import epas_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_write,
    input  cfg_index_t       cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    input  epas_cmd_t        cmd,
    input  logic [31:0]      s_tdata,
    input  logic             s_tuser,
    output epas_sts_t        sts,
    output logic [47:0]      m_tdata,
    output logic [3:0]       m_tuser,
    output logic             m_tlast
);

    logic [7:0]         device_address_reg;
    addr_mode_t         addressing_mode_reg;
    logic [PSIZE_W-1:0] page_size_reg;
    logic [PAGES_W-1:0] pages_per_device_reg;

    logic               wr_reg;
    logic [ADDR_W:0]    addr_reg;
    logic [COUNT_W-1:0] remain_reg;
    logic [COUNT_W-1:0] offset_reg;
    logic [CAP_W-1:0]   cap_reg;
    status_t            status_reg;
    logic [ADDR_W-1:0]  dvd_reg;
    logic [PSIZE_W-1:0] rem_reg;

    logic [PSIZE_W-1:0] psize;
    logic [CAP_W:0]     cap_prod;
    logic [ADDR_W:0]    end_addr;
    status_t            check_code;
    logic [PSIZE_W:0]   div_trial;
    logic [COUNT_W:0]   span;
    logic               crosses;
    logic [COUNT_W-1:0] len;
    logic [7:0]         sla;
    logic [ADDR_W-1:0]  sub;
    logic [1:0]         subn;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            device_address_reg   <= RST_DEVICE_ADDRESS;
            addressing_mode_reg  <= addr_mode_t'(RST_ADDRESSING_MODE);
            page_size_reg        <= RST_PAGE_SIZE;
            pages_per_device_reg <= RST_PAGES_PER_DEVICE;
        end else if (cfg_write) begin
            unique case (cfg_index)
                CFG_DEVICE_ADDRESS:   device_address_reg   <= cfg_data[7:0];
                CFG_ADDRESSING_MODE:  addressing_mode_reg  <= addr_mode_t'(cfg_data[1:0]);
                CFG_PAGE_SIZE:        page_size_reg        <= cfg_data[PSIZE_W-1:0];
                CFG_PAGES_PER_DEVICE: pages_per_device_reg <= cfg_data[PAGES_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (page_size_reg < PSIZE_MIN) begin
            psize = PSIZE_MIN;
        end else if (page_size_reg > PSIZE_MAX) begin
            psize = PSIZE_MAX;
        end else begin
            psize = page_size_reg;
        end
    end

    assign cap_prod = pages_per_device_reg * psize;
    assign end_addr = addr_reg + {{(ADDR_W+1-COUNT_W){1'b0}}, remain_reg};

    always_comb begin
        if (remain_reg == '0) begin
            check_code = ST_EMPTY;
        end else if (remain_reg > COUNT_W'(MAX_REQUEST_BYTES)) begin
            check_code = ST_LONG;
        end else if (CAP_W'(addr_reg) >= cap_reg || CAP_W'(end_addr) > cap_reg) begin
            check_code = ST_RANGE;
        end else if (addressing_mode_reg == MODE_INVALID) begin
            check_code = ST_MODE;
        end else begin
            check_code = ST_CHUNK;
        end
    end

    assign div_trial = {rem_reg, dvd_reg[ADDR_W-1]};

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            wr_reg     <= s_tuser;
            addr_reg   <= {1'b0, s_tdata[ADDR_W-1:0]};
            remain_reg <= s_tdata[ADDR_W+COUNT_W-1:ADDR_W];
            offset_reg <= '0;
            dvd_reg    <= s_tdata[ADDR_W-1:0];
            rem_reg    <= '0;
        end
        if (cmd.calc_cap) begin
            cap_reg <= cap_prod[CAP_W-1:0];
        end
        if (cmd.check) begin
            status_reg <= check_code;
        end
        if (cmd.div_step) begin
            dvd_reg <= {dvd_reg[ADDR_W-2:0], 1'b0};
            if (div_trial >= {1'b0, psize}) begin
                rem_reg <= PSIZE_W'(div_trial - {1'b0, psize});
            end else begin
                rem_reg <= div_trial[PSIZE_W-1:0];
            end
        end
        if (cmd.advance) begin
            addr_reg   <= addr_reg + (ADDR_W+1)'(len);
            offset_reg <= offset_reg + len;
            remain_reg <= remain_reg - len;
            rem_reg    <= '0;
        end
    end

    assign span    = {{(COUNT_W+1-PSIZE_W){1'b0}}, rem_reg} + {1'b0, remain_reg};
    assign crosses = span > {{(COUNT_W+1-PSIZE_W){1'b0}}, psize};
    assign len     = crosses ? COUNT_W'(psize - rem_reg) : remain_reg;

    always_comb begin
        if (addressing_mode_reg == MODE_EIGHT_PLUS_X) begin
            sla  = device_address_reg + {4'b0, addr_reg[10:8], 1'b0};
            sub  = {8'b0, addr_reg[7:0]};
            subn = 2'd1;
        end else begin
            sla  = device_address_reg;
            sub  = addr_reg[ADDR_W-1:0];
            subn = (addressing_mode_reg == MODE_TWO_BYTE) ? 2'd2 : 2'd1;
        end
    end

    always_comb begin
        if (status_reg != ST_CHUNK) begin
            m_tdata = '0;
            m_tlast = 1'b1;
        end else begin
            m_tdata = {3'b0, offset_reg, len[PSIZE_W-1:0], subn, sub, sla};
            m_tlast = !crosses;
        end
    end

    assign m_tuser = {status_reg, wr_reg};

    assign sts.check_code   = check_code;
    assign sts.final_result = m_tlast;

endmodule

/* rtl/eeprom_page_access_splitter.sv */
`timescale 1ns / 1ps

// Splits one serial-memory access request into page-bounded transfer
// descriptors. A request is taken only while the block is idle. After
// acceptance the capacity and the checks are registered in turn; a valid
// request then passes through the serial remainder unit that finds the start
// offset within its page. Then one descriptor is presented per cycle while
// m_tready is high, and the block is ready again in the cycle after the final
// result is taken.
// Configuration writes are always accepted and must only be issued while no
// request is in flight.

module eeprom_page_access_splitter
    import epas_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [31:0]      s_tdata,   // start_address, byte_count
    input  logic             s_tuser,   // req_type
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [47:0]      m_tdata,   // slave_address, sub_address,
                                        // sub_address_bytes, chunk_length,
                                        // buffer_offset
    output logic [3:0]       m_tuser,   // is_write, status
    output logic             m_tlast,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [1:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    epas_cmd_t cmd;
    epas_sts_t sts;

    assign cfg_ready = 1'b1;

    epas_controller u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    epas_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_index (cfg_index_t'(cfg_index)),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .sts       (sts),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

/* rtl/epas_checker.sv */
`timescale 1ns / 1ps

module epas_checker
    import epas_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic [3:0]  m_tuser,
    input logic        m_tlast
);

    // A stalled transaction keeps its payload.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
    else $error("stalled result changed");

    // A new request is never taken while a result is still pending.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |-> !m_tvalid)
    else $error("request accepted while a result is pending");

    // A status result is always the final one of its request.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[3:1] != ST_CHUNK |-> m_tlast && m_tdata == '0)
    else $error("status result malformed");

    // Every chunk moves at least one byte.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[3:1] == ST_CHUNK |-> m_tdata[34:26] != '0)
    else $error("empty chunk emitted");

endmodule

bind eeprom_page_access_splitter epas_checker u_epas_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
